/* src/ccm_pkg.sv */
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared types and constants for the colour correction matrix with clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package ccm_pkg;

  // fixed-point format
  localparam int unsigned COEFF_FRAC_BITS = 12;
  localparam int unsigned PIXEL_BITS      = 16;

  // field and register widths
  localparam int unsigned CHAN_BITS   = 16;
  localparam int unsigned COEFF_BITS  = 16;
  localparam int unsigned NUM_CHAN    = 3;
  localparam int unsigned ROW_BITS    = NUM_CHAN * COEFF_BITS;
  localparam int unsigned CFG_DATA_W  = ROW_BITS;
  localparam int unsigned CFG_IDX_W   = 2;

  // datapath widths: signed coeff times zero-extended pixel, three-term sum
  localparam int unsigned PROD_W = COEFF_BITS + PIXEL_BITS + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned SHF_W  = SUM_W - 1 - COEFF_FRAC_BITS;

  // full pixel range, zero-extended to the channel width
  localparam logic [CHAN_BITS-1:0] PIX_MAX =
    CHAN_BITS'((64'd1 << PIXEL_BITS) - 64'd1);

  // reset values of the matrix rows (identity) and the clamp
  localparam logic [ROW_BITS-1:0] ROW_RED_RST   = ROW_BITS'(48'd4096);
  localparam logic [ROW_BITS-1:0] ROW_GREEN_RST = ROW_BITS'(48'd4096 << 16);
  localparam logic [ROW_BITS-1:0] ROW_BLUE_RST  = ROW_BITS'(48'd4096 << 32);
  localparam logic [CHAN_BITS-1:0] CLAMP_RST    = '0;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_RED   = 2'd0,
    CFG_ROW_GREEN = 2'd1,
    CFG_ROW_BLUE  = 2'd2,
    CFG_CLAMP     = 2'd3
  } cfg_reg_e;

  // input word
  typedef struct packed {
    logic [CHAN_BITS-1:0] in_red;
    logic [CHAN_BITS-1:0] in_green;
    logic [CHAN_BITS-1:0] in_blue;
    logic                 in_frame_end;
  } pix_in_t;

  // output word
  typedef struct packed {
    logic [CHAN_BITS-1:0] out_red;
    logic [CHAN_BITS-1:0] out_green;
    logic [CHAN_BITS-1:0] out_blue;
    logic                 out_frame_end;
  } pix_out_t;

  // pixel vector handed to every lane, red in slot 0
  typedef logic [NUM_CHAN-1:0][PIXEL_BITS-1:0] pix_vec_t;

endpackage

`default_nettype wire

/* src/ccm_lane.sv */
// ----------------------------------------------------------------------------
// ccm_lane
// One matrix row: three registered products, then sum, shift and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_lane (
  input  wire logic                                 clk_i,
  input  wire logic                                 load_i,
  input  wire ccm_pkg::pix_vec_t                    px_i,
  input  wire logic [ccm_pkg::ROW_BITS-1:0]         row_i,
  input  wire logic [ccm_pkg::CHAN_BITS-1:0]        limit_i,
  output      logic [ccm_pkg::CHAN_BITS-1:0]        value_o
);

  logic signed [ccm_pkg::PROD_W-1:0] prod_q [ccm_pkg::NUM_CHAN];
  logic signed [ccm_pkg::PROD_W-1:0] prod_d [ccm_pkg::NUM_CHAN];
  logic signed [ccm_pkg::SUM_W-1:0]  sum;
  logic        [ccm_pkg::SHF_W-1:0]  shifted;

  // one multiplier per input channel
  always_comb begin
    for (int c = 0; c < ccm_pkg::NUM_CHAN; c++) begin
      prod_d[c] = $signed(row_i[c*ccm_pkg::COEFF_BITS +: ccm_pkg::COEFF_BITS])
                * $signed({1'b0, px_i[c]});
    end
  end

  // product registers, payload only
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int c = 0; c < ccm_pkg::NUM_CHAN; c++) begin
        prod_q[c] <= prod_d[c];
      end
    end
  end

  // exact sum, drop fraction bits, clamp to 0..limit
  always_comb begin
    sum = ccm_pkg::SUM_W'(prod_q[0]) + ccm_pkg::SUM_W'(prod_q[1])
        + ccm_pkg::SUM_W'(prod_q[2]);
    shifted = sum[ccm_pkg::SUM_W-2:ccm_pkg::COEFF_FRAC_BITS];
    if (sum[ccm_pkg::SUM_W-1]) begin
      value_o = '0;
    end else if (shifted > ccm_pkg::SHF_W'(limit_i)) begin
      value_o = limit_i;
    end else begin
      value_o = shifted[ccm_pkg::CHAN_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

/* src/ccm_merge.sv */
// ----------------------------------------------------------------------------
// ccm_merge
// Output register: gathers the three lane results and the frame marker.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_merge (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [ccm_pkg::CHAN_BITS-1:0] red_i,
  input  wire logic [ccm_pkg::CHAN_BITS-1:0] green_i,
  input  wire logic [ccm_pkg::CHAN_BITS-1:0] blue_i,
  input  wire logic                          frame_end_i,
  output      logic                          ready_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      ccm_pkg::pix_out_t             out_word_o
);

  logic              valid_q;
  ccm_pkg::pix_out_t word_q;

  // register may load when empty or when its word leaves
  assign ready_o = !valid_q || !out_stall_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q.out_red       <= red_i;
      word_q.out_green     <= green_i;
      word_q.out_blue      <= blue_i;
      word_q.out_frame_end <= frame_end_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

/* src/colour_matrix_pixel_clamp.sv */
// ----------------------------------------------------------------------------
// colour_matrix_pixel_clamp
// 3x3 colour correction matrix on RGB pixels, with an output clamp.
// ----------------------------------------------------------------------------
// One pixel word is taken per clock while the input is not stalled, and each
// result passes the product registers and then the output register. Three
// row lanes of three multipliers each work side by side; their products are
// registered, then each lane sums, drops the fraction bits and clamps to
// 0..clamp_bound (full pixel range when the bound is zero), and the output
// register joins the three channels with the frame marker. The product stage
// refills while a finished word waits on a stall, so the input only stalls
// when both stages hold words. Registers are written through cfg_we_i /
// cfg_idx_i / cfg_data_i and should change only while no pixel is in flight.
`default_nettype none

module colour_matrix_pixel_clamp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [ccm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ccm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input pixels
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire ccm_pkg::pix_in_t               in_word_i,
  // output pixels
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      ccm_pkg::pix_out_t              out_word_o
);

  logic [ccm_pkg::ROW_BITS-1:0]  row_red_q, row_green_q, row_blue_q;
  logic [ccm_pkg::CHAN_BITS-1:0] clamp_q;
  logic [ccm_pkg::CHAN_BITS-1:0] limit;
  logic                          prod_valid_q;
  logic                          frame_end_q;
  logic                          merge_ready;
  logic                          in_ready;
  logic                          in_take;
  ccm_pkg::pix_vec_t             px;
  logic [ccm_pkg::CHAN_BITS-1:0] red_val, green_val, blue_val;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_red_q   <= ccm_pkg::ROW_RED_RST;
      row_green_q <= ccm_pkg::ROW_GREEN_RST;
      row_blue_q  <= ccm_pkg::ROW_BLUE_RST;
      clamp_q     <= ccm_pkg::CLAMP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ccm_pkg::CFG_ROW_RED:   row_red_q   <= cfg_data_i;
        ccm_pkg::CFG_ROW_GREEN: row_green_q <= cfg_data_i;
        ccm_pkg::CFG_ROW_BLUE:  row_blue_q  <= cfg_data_i;
        ccm_pkg::CFG_CLAMP:     clamp_q     <= cfg_data_i[ccm_pkg::CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective upper limit
  always_comb begin
    if (clamp_q != '0 && clamp_q < ccm_pkg::PIX_MAX) begin
      limit = clamp_q;
    end else begin
      limit = ccm_pkg::PIX_MAX;
    end
  end

  // pixel channels cut to the pixel width
  assign px[0] = in_word_i.in_red[ccm_pkg::PIXEL_BITS-1:0];
  assign px[1] = in_word_i.in_green[ccm_pkg::PIXEL_BITS-1:0];
  assign px[2] = in_word_i.in_blue[ccm_pkg::PIXEL_BITS-1:0];

  // product stage handshake
  assign in_ready   = !prod_valid_q || merge_ready;
  assign in_stall_o = !in_ready;
  assign in_take    = in_valid_i && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (in_ready) begin
      prod_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      frame_end_q <= in_word_i.in_frame_end;
    end
  end

  // one lane per output channel
  ccm_lane u_lane_red (
    .clk_i   (clk_i),
    .load_i  (in_take),
    .px_i    (px),
    .row_i   (row_red_q),
    .limit_i (limit),
    .value_o (red_val)
  );

  ccm_lane u_lane_green (
    .clk_i   (clk_i),
    .load_i  (in_take),
    .px_i    (px),
    .row_i   (row_green_q),
    .limit_i (limit),
    .value_o (green_val)
  );

  ccm_lane u_lane_blue (
    .clk_i   (clk_i),
    .load_i  (in_take),
    .px_i    (px),
    .row_i   (row_blue_q),
    .limit_i (limit),
    .value_o (blue_val)
  );

  // output register
  ccm_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (prod_valid_q),
    .red_i       (red_val),
    .green_i     (green_val),
    .blue_i      (blue_val),
    .frame_end_i (frame_end_q),
    .ready_o     (merge_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // the input only stalls when both stages are full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (prod_valid_q && out_valid_o))
    else $error("input stalled with an empty stage");

  // an accepted word reaches the output register if the output is not blocked
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((in_valid_i && !in_stall_o) ##1 !out_stall_i) |=> out_valid_o)
    else $error("accepted word did not reach the output register");

  // a blocked product stage keeps its word
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_valid_q && !merge_ready) |=> (prod_valid_q && $stable(frame_end_q)))
    else $error("product stage lost a blocked word");

endmodule

`default_nettype wire
